// ===== rtl/uvs_pkg.sv =====
// Shared types and constants for the unique value set.
// Request/response payloads, operation codes and per-cell control.
`default_nettype none

package uvs_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  // Stored width: the request field carries 32 bits at most.
  localparam int unsigned VAL_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } uvs_req_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] count;
    logic       full_drop;
  } uvs_rsp_t;

  typedef struct packed {
    logic add_en;
    logic rm_en;
  } uvs_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/uvs_cell.sv =====
// One storage cell of the value chain: compare, append write, shift-down.
// Depends on uvs_pkg.
`default_nettype none

module uvs_cell
  import uvs_pkg::*;
(
  input  wire logic           clk_i,
  input  wire uvs_cell_ctrl_t ctrl_i,
  input  wire logic [VAL_W-1:0] key_i,
  input  wire logic           occ_i,
  input  wire logic           tail_i,
  input  wire logic [VAL_W-1:0] next_i,
  input  wire logic           seen_i,
  output logic                seen_o,
  output logic [VAL_W-1:0]    value_o
);

  logic [VAL_W-1:0] entry_q;
  logic [VAL_W-1:0] entry_d;
  logic             match;

  assign match   = occ_i && (entry_q == key_i);
  assign seen_o  = seen_i || match;
  assign value_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.add_en && tail_i) begin
      entry_d = key_i;
    end else if (ctrl_i.rm_en && seen_o) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== rtl/unique_value_set_unit.sv =====
// Unique value set: a chain of CAPACITY cells kept packed in insertion order.
// The response to an accepted request is registered and valid on the next cycle.
// Throughput: one request per cycle while the output is not stalled; all cells
// compare in parallel and a remove shifts the later cells down by one in the same cycle.
// Reset clears the held count and the response valid; cell contents are
// unspecified until written. Depends on uvs_pkg and uvs_cell.
`default_nettype none

module unique_value_set_unit
  import uvs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire uvs_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output uvs_rsp_t      out_rsp_o
);

  logic [CNT_W-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  uvs_rsp_t         rsp_q, rsp_d;

  logic             accept;
  logic [VAL_W-1:0] key;
  logic             hit;
  logic             full;
  uvs_cell_ctrl_t   ctrl;

  logic [CAPACITY:0]  seen;
  logic [VAL_W-1:0]   cell_val [CAPACITY+1];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign key         = in_req_i.value[VAL_W-1:0];
  assign full        = (held_q == CNT_W'(CAPACITY));
  assign hit         = seen[CAPACITY];
  assign seen[0]     = 1'b0;
  assign cell_val[CAPACITY] = '0;

  assign ctrl.add_en = accept && (in_req_i.op == OP_ADD) && !hit && !full;
  assign ctrl.rm_en  = accept && (in_req_i.op == OP_REMOVE) && hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] Idx = CNT_W'(i);
    uvs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .key_i   (key),
      .occ_i   (Idx < held_q),
      .tail_i  (Idx == held_q),
      .next_i  (cell_val[i+1]),
      .seen_i  (seen[i]),
      .seen_o  (seen[i+1]),
      .value_o (cell_val[i])
    );
  end

  always_comb begin
    held_d      = held_q;
    out_valid_d = out_valid_q && out_stall_i;
    rsp_d       = rsp_q;
    if (ctrl.add_en) begin
      held_d = held_q + CNT_W'(1);
    end else if (ctrl.rm_en) begin
      held_d = held_q - CNT_W'(1);
    end
    if (accept) begin
      out_valid_d     = 1'b1;
      rsp_d.hit       = hit;
      rsp_d.count     = 5'(held_d);
      rsp_d.full_drop = (in_req_i.op == OP_ADD) && !hit && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== verif/tb_unique_value_set_unit.sv =====
// Self-checking testbench for unique_value_set_unit: directed and random add, remove and
// lookup requests, checked against an in-bench model of the ordered set.
// Depends on uvs_pkg and the unique_value_set_unit RTL.
`default_nettype none

module tb_unique_value_set_unit;
  import uvs_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         MAX_REPORTS = 10;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  uvs_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  uvs_rsp_t out_rsp_o;

  logic [VAL_W-1:0] held_vals[$];
  uvs_rsp_t         pending_rsp_q[$];
  logic [31:0]      val_pool[$];
  int               mismatch_cnt = 0;
  bit               send_gaps    = 1'b0;
  bit               rsp_gaps     = 1'b0;
  bit               hold_off_req = 1'b0;

  unique_value_set_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("unique_value_set_unit regression: fail");
    $finish;
  end

  // Applies one request to the model set and returns the response it should produce.
  function automatic uvs_rsp_t set_update(input uvs_req_t req);
    uvs_rsp_t         rsp;
    logic [VAL_W-1:0] v;
    int               pos;
    v   = req.value[VAL_W-1:0];
    pos = -1;
    rsp = '0;
    foreach (held_vals[i]) begin
      if (pos < 0 && held_vals[i] == v) pos = i;
    end
    rsp.hit = (pos >= 0);
    case (req.op)
      OP_ADD: begin
        if (pos < 0) begin
          if (held_vals.size() < CAPACITY) held_vals = {held_vals, v};
          else rsp.full_drop = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) held_vals.delete(pos);
      end
      default: ;
    endcase
    rsp.count = 5'(held_vals.size());
    return rsp;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    uvs_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pending_rsp_q = {pending_rsp_q, set_update(in_req_i)};
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          flag_mismatch($sformatf("response with none pending: hit %0d count %0d drop %0d",
                                  out_rsp_o.hit, out_rsp_o.count, out_rsp_o.full_drop));
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp_o.hit !== want.hit)
            flag_mismatch($sformatf("hit expected %0d, got %0d", want.hit, out_rsp_o.hit));
          if (out_rsp_o.count !== want.count)
            flag_mismatch($sformatf("count expected %0d, got %0d",
                                    want.count, out_rsp_o.count));
          if (out_rsp_o.full_drop !== want.full_drop)
            flag_mismatch($sformatf("full_drop expected %0d, got %0d",
                                    want.full_drop, out_rsp_o.full_drop));
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Output stall: a long counted hold-off on request, else random short and long stalls.
  initial begin : rsp_stall_proc
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
        n = gap_len() + 1;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted; valid stays high.
  task automatic send_req(input logic [1:0] op, input logic [31:0] value);
    uvs_req_t req;
    int       gap;
    req.op    = op;
    req.value = value;
    gap       = send_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pool of values, some differing from another entry in a single bit.
  task automatic refill_pool(input int n);
    val_pool.delete();
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0)
        val_pool = {val_pool,
                    val_pool[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(0, 31))};
      else
        val_pool = {val_pool, 32'($urandom())};
    end
  endtask

  function automatic logic [31:0] pick_value();
    if (val_pool.size() == 0 || $urandom_range(0, 99) < 12) return $urandom();
    return val_pool[$urandom_range(0, val_pool.size() - 1)];
  endfunction

  function automatic logic [1:0] pick_op(input int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return OP_ADD;
    if (r < add_pct + (100 - add_pct) / 2) return OP_REMOVE;
    if (r < 97) return OP_LOOKUP;
    return OP_SPARE;
  endfunction

  task automatic test_basic_ops();
    send_req(OP_ADD, 32'h0000_0000);
    send_req(OP_ADD, 32'hFFFF_FFFF);
    send_req(OP_ADD, 32'h0000_0000);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF);
    send_req(OP_LOOKUP, 32'h0000_0005);
    send_req(OP_SPARE, 32'h0000_0000);
    send_req(OP_REMOVE, 32'h1234_5678);
    send_req(OP_REMOVE, 32'h0000_0000);
    end_burst();
  endtask

  // One value is held on entry; fills to capacity, then drops and compacts.
  task automatic test_fill_and_drop();
    for (int i = 0; i < 15; i++) send_req(OP_ADD, 32'h1 << i);
    send_req(OP_ADD, 32'hA5A5_A5A5);
    send_req(OP_ADD, 32'h1 << 3);
    send_req(OP_REMOVE, 32'h1 << 7);
    send_req(OP_LOOKUP, 32'h1 << 8);
    send_req(OP_ADD, 32'hA5A5_A5A5);
    end_burst();
  endtask

  task automatic test_backpressure();
    refill_pool(20);
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_req(pick_op(50), pick_value());
    end_burst();
  endtask

  task automatic test_random_mix();
    int add_pct;
    for (int phase = 0; phase < 22; phase++) begin
      refill_pool($urandom_range(3, 24));
      add_pct   = $urandom_range(15, 80);
      send_gaps = (phase % 3) != 0;
      rsp_gaps  = (phase % 4) != 1;
      for (int i = 0; i < 50; i++) send_req(pick_op(add_pct), pick_value());
    end
    end_burst();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gaps = 1'b1;
    rsp_gaps  = 1'b1;
    test_basic_ops();
    test_fill_and_drop();
    test_backpressure();
    test_random_mix();
    rsp_gaps = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("unique_value_set_unit regression: pass");
    else $display("unique_value_set_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/uvs_pkg.sv
rtl/uvs_cell.sv
rtl/unique_value_set_unit.sv
verif/tb_unique_value_set_unit.sv
